// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/dst_pkg.sv
`default_nettype none

package dst_pkg;

  // Default geometry of the table.
  localparam int DST_DEPTH     = 16;
  localparam int DST_KEY_WIDTH = 32;

  // Fixed field widths at the ports.
  localparam int KEY_IN_W = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 5;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ERASED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

  // One finished result as handed from the sequencer to the output stage.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [SLOT_W-1:0]   entry_count;
  } dst_res_t;

endpackage

`default_nettype wire

// File: rtl/dst_ram.sv
`default_nettype none

// Generic single-write, single-read RAM with a registered read port.
module dst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/dst_seq.sv
`default_nettype none

`include "assert_macros.svh"

// Sequencer: walks the table through the RAM, one access at a time, compares each
// entry against the key, and shifts entries down on an erase.
module dst_seq
  import dst_pkg::*;
#(
  parameter int DEPTH     = DST_DEPTH,
  parameter int KEY_WIDTH = DST_KEY_WIDTH,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [KEY_IN_W-1:0]  key_i,
  output logic                 ram_we_o,
  output logic [AW-1:0]        ram_waddr_o,
  output logic [KEY_WIDTH-1:0] ram_wdata_o,
  output logic                 ram_re_o,
  output logic [AW-1:0]        ram_raddr_o,
  input  logic [KEY_WIDTH-1:0] ram_rdata_i,
  output logic                 res_valid_o,
  input  logic                 res_take_i,
  output dst_res_t             res_o
);

  localparam int KW_IN = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_SH_RD = 3'd3;
  localparam logic [2:0] S_SH_WR = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  logic [CNT_W-1:0]     idx_nxt;
  logic [FUNC_W-1:0]    func_q, func_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  dst_res_t             res_q, res_d;
  logic                 accept;
  logic                 key_eq;

  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign idx_nxt = idx_q + CNT_W'(1);
  assign key_eq  = (ram_rdata_i == key_q);

  // Next-state and datapath control.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    func_d      = func_q;
    key_d       = key_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q[AW-1:0];
    ram_wdata_o = key_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_d = func_i;
          key_d  = KEY_WIDTH'(key_i[KW_IN-1:0]);
          idx_d  = '0;
          case (func_i)
            FUNC_INSERT, FUNC_ERASE: begin
              state_d = S_RD;
            end
            FUNC_CLEAR: begin
              count_d = '0;
              res_d   = '{status: ST_CLEARED, slot: '0, entry_count: '0};
              state_d = S_DONE;
            end
            default: begin
              res_d   = '{status: ST_NOT_FOUND, slot: SLOT_W'(count_q),
                          entry_count: SLOT_W'(count_q)};
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Fetch the next held entry, or finish the search without a match.
      S_RD: begin
        if (idx_q >= count_q) begin
          state_d = S_DONE;
          if (func_q != FUNC_INSERT) begin
            res_d = '{status: ST_NOT_FOUND, slot: SLOT_W'(count_q),
                      entry_count: SLOT_W'(count_q)};
          end else if (count_q >= CNT_FULL) begin
            res_d = '{status: ST_FULL, slot: SLOT_W'(count_q),
                      entry_count: SLOT_W'(count_q)};
          end else begin
            ram_we_o    = 1'b1;
            ram_waddr_o = count_q[AW-1:0];
            count_d     = count_q + CNT_W'(1);
            res_d       = '{status: ST_INSERTED, slot: SLOT_W'(count_q),
                            entry_count: SLOT_W'(count_q + CNT_W'(1))};
          end
        end else begin
          ram_re_o = 1'b1;
          state_d  = S_CMP;
        end
      end

      // Compare the fetched entry with the key.
      S_CMP: begin
        if (key_eq) begin
          if (func_q == FUNC_INSERT) begin
            res_d   = '{status: ST_DUPLICATE, slot: SLOT_W'(idx_q),
                        entry_count: SLOT_W'(count_q)};
            state_d = S_DONE;
          end else begin
            pos_d   = idx_q;
            state_d = S_SH_RD;
          end
        end else begin
          idx_d   = idx_nxt;
          state_d = S_RD;
        end
      end

      // Fetch the entry above the hole, or close the erase.
      S_SH_RD: begin
        if (idx_nxt >= count_q) begin
          count_d = count_q - CNT_W'(1);
          res_d   = '{status: ST_ERASED, slot: SLOT_W'(pos_q),
                      entry_count: SLOT_W'(count_q - CNT_W'(1))};
          state_d = S_DONE;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = idx_nxt[AW-1:0];
          state_d     = S_SH_WR;
        end
      end

      // Move the fetched entry down one slot.
      S_SH_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q[AW-1:0];
        ram_wdata_o = ram_rdata_i;
        idx_d       = idx_nxt;
        state_d     = S_SH_RD;
      end

      // Hold the result until the output stage takes it.
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    func_q <= func_d;
    key_q  <= key_d;
    res_q  <= res_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // The entry count never exceeds the table size.
  `ASSERT_NEVER(a_count_bound, count_q > CNT_FULL, "entry count above table depth")
  // A compare only ever looks at a held entry.
  `ASSERT_NEVER(a_cmp_held, (state_q == S_CMP) && (idx_q >= count_q), "compare beyond count")
  // The RAM is never asked to read and write at once.
  `ASSERT_NEVER(a_ram_port, ram_we_o && ram_re_o, "RAM read and write in one cycle")
  // The count moves by one per item, or drops to zero on a clear.
  `ASSERT_PROP(a_count_step, (count_q == $past(count_q)) || (count_q == '0) || (count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1)), "entry count jumped")

endmodule

`default_nettype wire

// File: rtl/dedup_set_table_unit.sv
`default_nettype none

// Duplicate-free set of keys held in insertion order in a table of DEPTH
// slots. Each item inserts, erases or clears (the fourth operation code is a
// no-op that reports not found); each yields exactly one result with a
// status, a slot index and the entry count after the operation. The table
// lives in a RAM with one write port and one registered read port, and the
// sequencer examines one entry at a time, a read (S_RD) then a compare
// (S_CMP). An erase then moves each entry above the match down one slot by a
// read and a write; a clear needs no walk. The input is stalled while an item
// is in work; a finished result waits in the output register so the next
// item can be accepted while the result is still stalled.
module dedup_set_table_unit
  import dst_pkg::*;
#(
  parameter int DEPTH     = DST_DEPTH,
  parameter int KEY_WIDTH = DST_KEY_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic signed [KEY_IN_W-1:0] key_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic [SLOT_W-1:0]     entry_count_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;
  logic                 res_valid;
  logic                 res_take;
  dst_res_t             res;
  logic                 out_vld_q, out_vld_d;
  dst_res_t             out_q;

  // Entry storage.
  dst_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Search and shift sequencer.
  dst_seq #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .key_i       (key_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  // The output register takes a result when it is empty or being drained.
  assign res_take = res_valid && (!out_vld_q || !out_stall_i);

  always_comb begin
    out_vld_d = out_vld_q;
    if (res_take) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_q.status;
  assign slot_o        = out_q.slot;
  assign entry_count_o = out_q.entry_count;

endmodule

`default_nettype wire

// File: sim/tb_dedup_set_table_unit.sv
`default_nettype none

module tb_dedup_set_table_unit;
  import dst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = DST_DEPTH;
  localparam int KEY_POOL_N  = 20;
  localparam int PHASE_ITEMS = 185;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 100;
  localparam int REPORT_MAX  = 10;

  // The port allows a fourth operation code that the block treats as a no-op.
  localparam logic [FUNC_W-1:0] FUNC_UNDEF = 2'd3;

  // One row of the directed part; a row repeats reps times with an incrementing key.
  typedef struct packed {
    logic [FUNC_W-1:0]   op;
    logic [KEY_IN_W-1:0] key;
    logic [4:0]          reps;
    logic                known;
    dst_res_t            want;
  } dir_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [FUNC_W-1:0]          func_i = FUNC_INSERT;
  logic signed [KEY_IN_W-1:0] key_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [STATUS_W-1:0]        status_o;
  logic [SLOT_W-1:0]          slot_o;
  logic [SLOT_W-1:0]          entry_count_o;

  // Shadow copy of the table and the results still owed by the block.
  logic [KEY_IN_W-1:0] shadow_keys [DEPTH];
  int unsigned         shadow_count;
  dst_res_t            owed_results [$];

  dir_row_t            dir_rows [$];
  logic [KEY_IN_W-1:0] key_pool [KEY_POOL_N];
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  mismatch_count = 0;
  int                  item_count = 0;
  int                  cycle_count = 0;
  int                  status_seen [6];

  dedup_set_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .key_i         (key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .entry_count_o (entry_count_o)
  );

  always #2 clk_i = ~clk_i;

  // Append one row to the directed table.
  function automatic void add_row(input logic [FUNC_W-1:0] op,
                                  input logic [KEY_IN_W-1:0] key,
                                  input logic [4:0] reps,
                                  input logic known,
                                  input dst_res_t want);
    dir_row_t row;
    row.op    = op;
    row.key   = key;
    row.reps  = reps;
    row.known = known;
    row.want  = want;
    dir_rows  = {dir_rows, row};
  endfunction

  // Queue one expected result behind those already owed.
  function automatic void owe_result(input dst_res_t res);
    owed_results = {owed_results, res};
  endfunction

  // Apply one operation to the shadow table and return the result it yields.
  function automatic dst_res_t table_apply(input logic [FUNC_W-1:0] op,
                                           input logic [KEY_IN_W-1:0] key);
    dst_res_t    res;
    int unsigned pos;
    int unsigned i;
    pos = shadow_count;
    for (i = 0; i < shadow_count; i++) begin
      if (pos == shadow_count && shadow_keys[i] == key) begin
        pos = i;
      end
    end
    case (op)
      FUNC_INSERT: begin
        if (pos < shadow_count) begin
          res.status = ST_DUPLICATE;
          res.slot   = pos[SLOT_W-1:0];
        end else if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
          res.slot   = shadow_count[SLOT_W-1:0];
        end else begin
          shadow_keys[shadow_count] = key;
          res.status = ST_INSERTED;
          res.slot   = shadow_count[SLOT_W-1:0];
          shadow_count++;
        end
      end
      FUNC_ERASE: begin
        if (pos < shadow_count) begin
          for (i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
          end
          shadow_count--;
          res.status = ST_ERASED;
          res.slot   = pos[SLOT_W-1:0];
        end else begin
          res.status = ST_NOT_FOUND;
          res.slot   = shadow_count[SLOT_W-1:0];
        end
      end
      FUNC_CLEAR: begin
        shadow_count = 0;
        res.status   = ST_CLEARED;
        res.slot     = '0;
      end
      default: begin
        res.status = ST_NOT_FOUND;
        res.slot   = shadow_count[SLOT_W-1:0];
      end
    endcase
    res.entry_count = shadow_count[SLOT_W-1:0];
    return res;
  endfunction

  // Present one item, with random idle cycles first, and wait until it is taken.
  task automatic send_item(input logic [FUNC_W-1:0] op, input logic [KEY_IN_W-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= op;
    key_i      <= key;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    item_count++;
  endtask

  // Hold the input idle until every owed result has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (owed_results.size() != 0);
  endtask

  // Result side: random stall, and every accepted result against the oldest owed one.
  always @(posedge clk_i) begin
    dst_res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (status_o < 6) begin
          status_seen[status_o]++;
        end
        if (owed_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("[%0t] unexpected result: status %0d slot %0d count %0d",
                     $realtime, status_o, slot_o, entry_count_o);
          end
        end else begin
          want = owed_results.pop_front();
          if (status_o !== want.status || slot_o !== want.slot ||
              entry_count_o !== want.entry_count) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
              $display("[%0t] mismatch: expected status %0d slot %0d count %0d, got %0d %0d %0d",
                       $realtime, want.status, want.slot, want.entry_count,
                       status_o, slot_o, entry_count_o);
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog on the cycle count.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results still owed.",
             cycle_count, owed_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus: directed rows first, then four random phases with different pacing.
  initial begin
    dst_res_t          res;
    dir_row_t          row;
    logic [FUNC_W-1:0] op;
    logic [KEY_IN_W-1:0] key;
    int                pick;
    int                phase;
    int                n;
    int                r;

    shadow_count = 0;
    for (n = 0; n < DEPTH; n++) begin
      shadow_keys[n] = '0;
    end
    for (n = 0; n < 6; n++) begin
      status_seen[n] = 0;
    end

    // Extremes of the key, an empty table, a full table, first and last slots.
    add_row(FUNC_ERASE, 32'h0000_0005, 5'd1, 1'b1, '{ST_NOT_FOUND, 5'd0, 5'd0});
    add_row(FUNC_UNDEF, 32'h0000_0000, 5'd1, 1'b1, '{ST_NOT_FOUND, 5'd0, 5'd0});
    add_row(FUNC_CLEAR, 32'hFFFF_FFFF, 5'd1, 1'b1, '{ST_CLEARED, 5'd0, 5'd0});
    add_row(FUNC_INSERT, 32'h7FFF_FFFF, 5'd1, 1'b1, '{ST_INSERTED, 5'd0, 5'd1});
    add_row(FUNC_INSERT, 32'h8000_0000, 5'd1, 1'b1, '{ST_INSERTED, 5'd1, 5'd2});
    add_row(FUNC_INSERT, 32'h0000_0000, 5'd1, 1'b1, '{ST_INSERTED, 5'd2, 5'd3});
    add_row(FUNC_INSERT, 32'hFFFF_FFFF, 5'd1, 1'b1, '{ST_INSERTED, 5'd3, 5'd4});
    add_row(FUNC_INSERT, 32'h8000_0000, 5'd1, 1'b1, '{ST_DUPLICATE, 5'd1, 5'd4});
    add_row(FUNC_ERASE, 32'h7FFF_FFFF, 5'd1, 1'b0, '0);
    add_row(FUNC_ERASE, 32'h1234_5678, 5'd1, 1'b0, '0);
    add_row(FUNC_UNDEF, 32'hFFFF_FFFF, 5'd1, 1'b0, '0);
    add_row(FUNC_INSERT, 32'h0000_0100, 5'd13, 1'b0, '0);
    add_row(FUNC_INSERT, 32'h55AA_55AA, 5'd1, 1'b1, '{ST_FULL, 5'd16, 5'd16});
    add_row(FUNC_INSERT, 32'h0000_0000, 5'd1, 1'b0, '0);
    add_row(FUNC_ERASE, 32'h0000_010C, 5'd1, 1'b0, '0);
    add_row(FUNC_INSERT, 32'h55AA_55AA, 5'd1, 1'b0, '0);
    add_row(FUNC_ERASE, 32'hFFFF_FFFF, 5'd1, 1'b0, '0);
    add_row(FUNC_ERASE, 32'hFFFF_FFFF, 5'd1, 1'b0, '0);
    add_row(FUNC_CLEAR, 32'h0000_0000, 5'd1, 1'b1, '{ST_CLEARED, 5'd0, 5'd0});
    add_row(FUNC_INSERT, 32'hAAAA_AAAA, 5'd1, 1'b1, '{ST_INSERTED, 5'd0, 5'd1});
    add_row(FUNC_ERASE, 32'hAAAA_AAAA, 5'd1, 1'b1, '{ST_ERASED, 5'd0, 5'd0});

    // Key pool: extremes, a few keys one bit apart, and the rest random.
    for (n = 0; n < KEY_POOL_N; n++) begin
      key_pool[n] = $urandom;
    end
    key_pool[0] = 32'h7FFF_FFFF;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    key_pool[5] = key_pool[4] ^ 32'h0000_0001;
    key_pool[6] = key_pool[4] ^ 32'h8000_0000;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with light pacing on both sides.
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      for (n = 0; n < row.reps; n++) begin
        key = row.key + n;
        send_item(row.op, key);
        res = table_apply(row.op, key);
        owe_result(row.known ? row.want : res);
      end
    end

    // Random phases; each starts from a drained block.
    for (phase = 0; phase < 4; phase++) begin
      drain_results();
      send_idle_pct  = (phase == 1) ? 55 : (phase == 3) ? 29 : 0;
      recv_stall_pct = (phase == 2) ? 55 : (phase == 3) ? 29 : 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 199);
        if (r < 3) begin
          op = FUNC_CLEAR;
        end else if (r < 7) begin
          op = FUNC_UNDEF;
        end else if (r < 125) begin
          op = FUNC_INSERT;
        end else begin
          op = FUNC_ERASE;
        end
        // Half of the erases on a non-empty table target held keys so that removals from every slot occur.
        pick = $urandom_range(0, 99);
        if (op == FUNC_ERASE && shadow_count > 0 && pick < 50) begin
          key = shadow_keys[$urandom_range(0, shadow_count - 1)];
        end else if (pick < 80) begin
          key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
        end else begin
          key = $urandom;
        end
        send_item(op, key);
        owe_result(table_apply(op, key));
      end
    end

    // Let the last results out, then watch for anything extra.
    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d items in directed and four paced random phases.", item_count);
    $display("Results: %0d inserted, %0d duplicate, %0d erased, %0d not found, %0d full, %0d cleared.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches.", mismatch_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
